@@ src/sdft_pkg.sv @@
// Shared types, constants and twiddle functions for the sliding DFT core.
// Used by sdft_cell and sliding_dft_half_spectrum_core; no dependencies.
`default_nettype none

package sdft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int BIN_W    = 32;
	localparam int TW_W     = 18;
	localparam int INDEX_W  = 6;
	localparam int RND_W    = 36;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	localparam int TAYLOR_TERMS = 12;

	// Divisors of the Taylor terms: (2n)(2n+1) for sine, (2n-1)(2n) for cosine.
	localparam logic [9:0] SIN_DIV [TAYLOR_TERMS] = '{
		10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
		10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600};
	localparam logic [9:0] COS_DIV [TAYLOR_TERMS] = '{
		10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
		10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552};

	// Token and sample difference handed from one cell to the next.
	typedef struct packed {
		logic                      valid;
		logic signed [DIFF_W-1:0]  d;
	} link_t;

	// Freshly updated bin value of one cell.
	typedef struct packed {
		logic                      valid;
		logic signed [BIN_W-1:0]   re;
		logic signed [BIN_W-1:0]   im;
	} bin_t;

	function automatic logic signed [TW_W-1:0] q30_to_q16(input logic signed [63:0] v);
		logic [63:0] u;
		u = (v < 64'sd0) ? 64'd0 : v;
		u = (u + 64'd8192) >> 14;
		return u[TW_W-1:0];
	endfunction

	function automatic logic signed [TW_W-1:0] twiddle_sin(input logic [63:0] angle);
		logic [63:0]        term;
		logic signed [63:0] acc;
		term = angle;
		acc  = $signed(angle);
		for (int n = 0; n < TAYLOR_TERMS; n++) begin
			term = (((term * angle) >> 30) * angle) >> 30;
			term = term / 64'(SIN_DIV[n]);
			if (n % 2 == 0) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		return q30_to_q16(acc);
	endfunction

	function automatic logic signed [TW_W-1:0] twiddle_cos(input logic [63:0] angle,
			input logic flip);
		logic [63:0]           term;
		logic signed [63:0]    acc;
		logic signed [TW_W-1:0] mag;
		term = ONE_Q30;
		acc  = $signed(ONE_Q30);
		for (int n = 0; n < TAYLOR_TERMS; n++) begin
			term = (((term * angle) >> 30) * angle) >> 30;
			term = term / 64'(COS_DIV[n]);
			if (n % 2 == 0) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		mag = q30_to_q16(acc);
		return flip ? -mag : mag;
	endfunction

	function automatic logic signed [BIN_W-1:0] sat32(input logic signed [RND_W-1:0] v);
		if (v > 36'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[BIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/sdft_cell.sv @@
// One bin of the sliding DFT: holds X_k and updates it when the token passes.
// Depends on sdft_pkg for the link and bin types and the saturation function.
`default_nettype none

module sdft_cell #(
	parameter logic signed [17:0] COS_Q16 = 18'sd65536,
	parameter logic signed [17:0] SIN_Q16 = 18'sd0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire sdft_pkg::link_t link_in,
	output sdft_pkg::link_t     link_out,
	output sdft_pkg::bin_t      res
);

	logic signed [sdft_pkg::BIN_W-1:0]  x_re_q, x_im_q;
	logic signed [sdft_pkg::BIN_W:0]    sr;
	logic                               v_s1;
	logic signed [sdft_pkg::DIFF_W-1:0] d_s1;
	logic signed [50:0]                 p_rc_s1, p_rs_s1;
	logic signed [49:0]                 p_is_s1, p_ic_s1;
	logic signed [51:0]                 acc_re, acc_im;
	logic signed [sdft_pkg::RND_W-1:0]  rnd_re, rnd_im;
	logic signed [sdft_pkg::BIN_W-1:0]  new_re, new_im;

	assign sr = 33'(x_re_q) + 33'($signed(link_in.d));

	// Stage one: the four products of the complex multiply.
	always_ff @(posedge clk) begin
		if (adv && link_in.valid) begin
			p_rc_s1 <= sr * COS_Q16;
			p_rs_s1 <= sr * SIN_Q16;
			p_is_s1 <= x_im_q * SIN_Q16;
			p_ic_s1 <= x_im_q * COS_Q16;
			d_s1    <= link_in.d;
		end
	end

	// Stage two: round half up to an integer, then saturate.
	always_comb begin
		acc_re = 52'(p_rc_s1) - 52'(p_is_s1) + 52'sd32768;
		acc_im = 52'(p_rs_s1) + 52'(p_ic_s1) + 52'sd32768;
		rnd_re = 36'(acc_re >>> 16);
		rnd_im = 36'(acc_im >>> 16);
		new_re = sdft_pkg::sat32(rnd_re);
		new_im = sdft_pkg::sat32(rnd_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			x_re_q <= '0;
			x_im_q <= '0;
		end else if (adv) begin
			v_s1 <= link_in.valid;
			if (v_s1) begin
				x_re_q <= new_re;
				x_im_q <= new_im;
			end
		end
	end

	assign link_out.valid = v_s1;
	assign link_out.d     = d_s1;
	assign res.valid      = v_s1;
	assign res.re         = new_re;
	assign res.im         = new_im;

endmodule

`default_nettype wire

@@ src/sliding_dft_half_spectrum_core.sv @@
// A result for bin k passes start_q, the stage register of cells 0 to k, and the output register.
// A new sample is taken only once the token has left the last cell. Unless the output
// stalls, a token walks the cell chain one cell per cycle; each cell spends two stages.
// Output stalls freeze the whole chain. Reset (arst_n low) clears window, bins and counts.
// Sliding DFT top level: sample shift line, fill count, cell chain and output register.
// Depends on sdft_pkg and sdft_cell.
`default_nettype none

module sliding_dft_half_spectrum_core #(
	parameter int WINDOW_LENGTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [15:0] sample_in
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,  // [5:0] bin_index, [37:6] bin_real, [69:38] bin_imag, zeros
	output logic        m_tuser,  // [0] spectrum_ready
	output logic        m_tlast   // last_bin
);

	localparam int NUM_BINS = WINDOW_LENGTH / 2 + 1;
	localparam int FILL_W   = $clog2(WINDOW_LENGTH + 1);

	logic signed [sdft_pkg::SAMPLE_W-1:0] win_q [WINDOW_LENGTH];
	logic [FILL_W-1:0]                    fill_q;
	logic                                 ready_q, busy_q, start_q;
	logic signed [sdft_pkg::DIFF_W-1:0]   d_q, d_new;
	logic                                 accept, adv;

	sdft_pkg::link_t link [NUM_BINS+1];
	sdft_pkg::bin_t  res  [NUM_BINS];

	sdft_pkg::bin_t                       sel;
	logic [sdft_pkg::INDEX_W-1:0]         sel_idx;

	logic                                 out_valid_q, out_last_q, out_rdy_q;
	logic [sdft_pkg::INDEX_W-1:0]         out_idx_q;
	logic signed [sdft_pkg::BIN_W-1:0]    out_re_q, out_im_q;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign adv      = !out_valid_q || m_tready;

	assign d_new = 17'($signed(s_tdata)) - 17'(win_q[WINDOW_LENGTH-1]);

	// The window is a shift line: the tap at the far end is the sample leaving it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			win_q[0] <= $signed(s_tdata);
			for (int i = 1; i < WINDOW_LENGTH; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ready_q <= 1'b0;
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			if (accept) begin
				if (fill_q < FILL_W'(WINDOW_LENGTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				ready_q <= (fill_q >= FILL_W'(WINDOW_LENGTH - 1));
				busy_q  <= 1'b1;
				start_q <= 1'b1;
			end else begin
				if (adv) begin
					start_q <= 1'b0;
				end
				if (adv && link[NUM_BINS].valid) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q <= d_new;
		end
	end

	assign link[0].valid = start_q;
	assign link[0].d     = d_q;

	for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
		localparam logic [63:0] P_RAW  = 64'(2 * k);
		localparam bit          FLIP   = (2 * P_RAW > 64'(WINDOW_LENGTH));
		localparam logic [63:0] P_FOLD = FLIP ? 64'(WINDOW_LENGTH) - P_RAW : P_RAW;
		localparam logic [63:0] ANGLE  = (sdft_pkg::PI_Q30 * P_FOLD) / WINDOW_LENGTH;
		localparam logic signed [17:0] COS_K = sdft_pkg::twiddle_cos(ANGLE, FLIP);
		localparam logic signed [17:0] SIN_K = sdft_pkg::twiddle_sin(ANGLE);

		sdft_cell #(
			.COS_Q16 (COS_K),
			.SIN_Q16 (SIN_K)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.link_in  (link[k]),
			.link_out (link[k+1]),
			.res      (res[k])
		);
	end

	// At most one cell finishes per cycle, so the pick below is one-hot.
	always_comb begin
		sel     = '0;
		sel_idx = '0;
		for (int k = 0; k < NUM_BINS; k++) begin
			if (res[k].valid) begin
				sel     = res[k];
				sel_idx = sdft_pkg::INDEX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && sel.valid) begin
			out_idx_q  <= sel_idx;
			out_re_q   <= sel.re;
			out_im_q   <= sel.im;
			out_last_q <= res[NUM_BINS-1].valid;
			out_rdy_q  <= ready_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_im_q, out_re_q, out_idx_q};
	assign m_tuser  = out_rdy_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ src/sdft_checker.sv @@
// Port-level checks for sliding_dft_half_spectrum_core, attached by the bind below.
// Looks at the top level's ports only; no package dependency.
`default_nettype none

module sdft_checker #(
	parameter int WINDOW_LENGTH = 64
) (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata,
	input wire        m_tuser,
	input wire        m_tlast
);

	// A new sample is only taken once the previous spectrum is fully computed.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a spectrum is in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(WINDOW_LENGTH / 2))
		else $error("last item is not the top bin");

	// Once the window has filled, it stays full until reset.
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tuser |=> m_tuser)
		else $error("spectrum ready flag dropped");

endmodule

bind sliding_dft_half_spectrum_core sdft_checker #(
	.WINDOW_LENGTH (WINDOW_LENGTH)
) u_sdft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/sliding_dft_half_spectrum_checker.sv @@
// Checker for the sliding DFT core: watches the sample and bin streams, predicts every bin.
// Builds its own twiddle table; needs only the port layout of sliding_dft_half_spectrum_core.
`timescale 1ns / 1ps

module sliding_dft_half_spectrum_checker #(
	parameter int WINDOW_LENGTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [15:0] s_tdata,  // [15:0] sample_in
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [71:0] m_tdata,  // [5:0] bin_index, [37:6] bin_real, [69:38] bin_imag, zeros
	input  wire         m_tuser,  // [0] spectrum_ready
	input  wire         m_tlast,
	output int          mismatch_count,
	output int          bins_outstanding,
	output int          bins_checked
);

	localparam int NUM_BINS = WINDOW_LENGTH / 2 + 1;
	localparam bit [63:0] PI_Q30 = 64'd3373259426;
	localparam bit [63:0] ONE_Q30 = 64'd1073741824;
	localparam int SERIES_TERMS = 12;
	localparam longint BIN_MAX = 64'sd2147483647;
	localparam longint BIN_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [5:0]          index;
		logic signed [31:0]  re;
		logic signed [31:0]  im;
		logic                ready;
		logic                last;
	} bin_result_t;

	int cos_rom [NUM_BINS];
	int sin_rom [NUM_BINS];

	logic signed [15:0] window [WINDOW_LENGTH];
	logic signed [31:0] bin_re [NUM_BINS];
	logic signed [31:0] bin_im [NUM_BINS];
	int oldest_slot;
	int samples_seen;

	bin_result_t bins_due [$];

	initial begin
		mismatch_count = 0;
		bins_checked = 0;
		bins_outstanding = 0;
	end

	function automatic int round_to_q16(input longint v);
		longint unsigned u;
		u = (v < 0) ? 64'd0 : 64'(v);
		return int'((u + 64'd8192) >> 14);
	endfunction

	// Integer Taylor series in Q30 on the angle folded into the first quadrant.
	initial begin
		bit [63:0] p, ang, st, ct;
		longint s_acc, c_acc;
		bit mirror;
		for (int k = 0; k < NUM_BINS; k++) begin
			p = 64'(2 * k);
			mirror = 1'b0;
			if (2 * p > WINDOW_LENGTH) begin
				p = WINDOW_LENGTH - p;
				mirror = 1'b1;
			end
			ang = (PI_Q30 * p) / WINDOW_LENGTH;
			st = ang;
			s_acc = longint'(ang);
			ct = ONE_Q30;
			c_acc = longint'(ONE_Q30);
			for (int n = 1; n <= SERIES_TERMS; n++) begin
				st = (((st * ang) >> 30) * ang) >> 30;
				st = st / 64'((2 * n) * (2 * n + 1));
				ct = (((ct * ang) >> 30) * ang) >> 30;
				ct = ct / 64'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					s_acc -= longint'(st);
					c_acc -= longint'(ct);
				end else begin
					s_acc += longint'(st);
					c_acc += longint'(ct);
				end
			end
			sin_rom[k] = round_to_q16(s_acc);
			cos_rom[k] = mirror ? -round_to_q16(c_acc) : round_to_q16(c_acc);
		end
	end

	// Ties round toward +infinity: add half, then floor by arithmetic shift.
	function automatic logic signed [31:0] round_and_clip(input longint v);
		longint r;
		r = (v + 64'sd32768) >>> 16;
		if (r > BIN_MAX) begin
			return 32'sh7fffffff;
		end else if (r < BIN_MIN) begin
			return 32'sh80000000;
		end
		return r[31:0];
	endfunction

	task automatic slide_in_sample(input logic [15:0] raw);
		longint delta, sr, si;
		bin_result_t r;
		logic ready;
		delta = longint'($signed(raw)) - longint'(window[oldest_slot]);
		window[oldest_slot] = $signed(raw);
		oldest_slot = (oldest_slot + 1) % WINDOW_LENGTH;
		if (samples_seen < WINDOW_LENGTH) begin
			samples_seen++;
		end
		ready = (samples_seen >= WINDOW_LENGTH);
		for (int k = 0; k < NUM_BINS; k++) begin
			sr = longint'(bin_re[k]) + delta;
			si = longint'(bin_im[k]);
			bin_re[k] = round_and_clip(sr * cos_rom[k] - si * sin_rom[k]);
			bin_im[k] = round_and_clip(sr * sin_rom[k] + si * cos_rom[k]);
			r.index = 6'(k);
			r.re = bin_re[k];
			r.im = bin_im[k];
			r.ready = ready;
			r.last = (k == NUM_BINS - 1);
			bins_due.push_back(r);
		end
	endtask

	task automatic report(input string field, input int k, input longint want, input longint got);
		$display("%0t ns: bin %0d %s mismatch, expected %0d, actual %0d",
			$time, k, field, want, got);
		mismatch_count++;
	endtask

	task automatic check_bin();
		bin_result_t want;
		if (bins_due.size() == 0) begin
			$display("%0t ns: bin result with none outstanding, actual index %0d re %0d im %0d",
				$time, m_tdata[5:0], $signed(m_tdata[37:6]), $signed(m_tdata[69:38]));
			mismatch_count++;
		end else begin
			want = bins_due.pop_front();
			bins_checked++;
			if (m_tdata[5:0] !== want.index)
				report("index", want.index, want.index, m_tdata[5:0]);
			if (m_tdata[37:6] !== want.re)
				report("real", want.index, want.re, $signed(m_tdata[37:6]));
			if (m_tdata[69:38] !== want.im)
				report("imag", want.index, want.im, $signed(m_tdata[69:38]));
			if (m_tuser !== want.ready)
				report("spectrum_ready", want.index, want.ready, m_tuser);
			if (m_tlast !== want.last)
				report("last_bin", want.index, want.last, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++)
				window[i] = '0;
			for (int k = 0; k < NUM_BINS; k++) begin
				bin_re[k] = '0;
				bin_im[k] = '0;
			end
			oldest_slot = 0;
			samples_seen = 0;
			bins_due.delete();
			bins_outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				slide_in_sample(s_tdata);
			if (m_tvalid && m_tready)
				check_bin();
			bins_outstanding <= bins_due.size();
		end
	end

endmodule

@@ test/sliding_dft_half_spectrum_core_test.sv @@
// Testbench top for sliding_dft_half_spectrum_core: sample stimulus, output back-pressure, verdict.
// Depends on the core and on sliding_dft_half_spectrum_checker for prediction and comparison.
`timescale 1ns / 1ps

module sliding_dft_half_spectrum_core_test;

	localparam int WINDOW = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int mismatch_count;
	int bins_outstanding;
	int bins_checked;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int samples_sent = 0;
	int cycle_count = 0;

	sliding_dft_half_spectrum_core #(.WINDOW_LENGTH(WINDOW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	sliding_dft_half_spectrum_checker #(.WINDOW_LENGTH(WINDOW)) spectrum_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.mismatch_count(mismatch_count), .bins_outstanding(bins_outstanding),
		.bins_checked(bins_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out with %0d bin results still outstanding.", bins_outstanding);
			$display("sliding_dft_half_spectrum_core_test: done, errors");
			$finish;
		end
	end

	// Output back-pressure; a requested long hold keeps tready low and so freezes the core.
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			hold_left = LONG_HOLD;
			holds_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_sample(input logic [15:0] x);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (bins_outstanding != 0);
	endtask

	// Mostly full-range noise, with extremes and small values mixed in.
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($signed(5'($urandom_range(31))));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_sample(pick_sample());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 11;
		rx_idle_pct = 80;

		// Extremes first, then a full-scale alternation that drives the Nyquist bin hard.
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		repeat (4) send_sample(16'h7FFF);
		repeat (4) send_sample(16'h8000);
		for (int i = 0; i < 8; i++)
			send_sample(i % 2 ? 16'h8000 : 16'h7FFF);
		send_sample(16'h0000);

		// The window fills during this stretch, so spectrum_ready rises here.
		send_random(140);
		drain();

		tx_idle_pct = 80;
		rx_idle_pct = 11;
		send_random(150);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holds_asked++;
		send_random(30);
		drain();
		send_random(140);
		drain();

		repeat (40) @(posedge clk);
		$display("Sent %0d samples and checked %0d bin results under three idle mixes,",
			samples_sent, bins_checked);
		$display("with a long output stall and a full drain between phases.");
		if (mismatch_count == 0) begin
			$display("sliding_dft_half_spectrum_core_test: done, clean");
		end else begin
			$display("sliding_dft_half_spectrum_core_test: done, errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/sdft_pkg.sv
src/sdft_cell.sv
src/sliding_dft_half_spectrum_core.sv
src/sdft_checker.sv
test/sliding_dft_half_spectrum_checker.sv
test/sliding_dft_half_spectrum_core_test.sv
